// ===== sv/mss_pkg.sv =====
// shared types, constants and segment lookup for the seven-segment scanner
package mss_pkg;

    localparam int NUM_W      = 16;
    localparam int SEG_W      = 8;
    localparam int POS_W      = 3;
    localparam int QUOT_W     = 14;
    localparam int DIGIT_W    = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 2;
    localparam int MULT_W     = 31;
    localparam int SHIFT_W    = 5;

    localparam logic [NUM_W-1:0] NUM_MAX = 16'd9999;

    // reciprocal multipliers, exact for values up to 9999
    localparam logic [15:0] RECIP_10   = 16'd52429;
    localparam logic [15:0] RECIP_100  = 16'd5243;
    localparam logic [15:0] RECIP_1000 = 16'd8389;
    localparam logic [SHIFT_W-1:0] SHIFT_10   = 5'd19;
    localparam logic [SHIFT_W-1:0] SHIFT_100  = 5'd19;
    localparam logic [SHIFT_W-1:0] SHIFT_1000 = 5'd23;

    localparam logic [SEG_W-1:0] SEG_DARK      = 8'hFF;
    localparam logic [SEG_W-1:0] COLON_LIT     = 8'h03;
    localparam logic [SEG_W-1:0] COLON_DOT_LIT = 8'h07;

    localparam int COLON_ON_BIT  = 0;
    localparam int COLON_DOT_BIT = 1;

    typedef enum logic [POS_W-1:0] {
        POS_ONES      = 3'd0,
        POS_TENS      = 3'd1,
        POS_COLON     = 3'd2,
        POS_HUNDREDS  = 3'd3,
        POS_THOUSANDS = 3'd4
    } pos_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ZERO_FILL  = 1'b0,
        CFG_COLON_MODE = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic       zero_fill;
        logic [1:0] colon_mode;
    } cfg_t;

    // one classified scan slot waiting for the back end
    typedef struct packed {
        pos_t              position;
        logic [QUOT_W-1:0] quot;
        logic              blank;
    } slot_item_t;

    function automatic logic [SEG_W-1:0] digit_pattern(input logic [DIGIT_W-1:0] d);
        logic [SEG_W-1:0] lit;
        case (d)
            4'd0:    lit = 8'h3F;
            4'd1:    lit = 8'h06;
            4'd2:    lit = 8'h5B;
            4'd3:    lit = 8'h4F;
            4'd4:    lit = 8'h66;
            4'd5:    lit = 8'h6D;
            4'd6:    lit = 8'h7C;
            4'd7:    lit = 8'h07;
            4'd8:    lit = 8'h7F;
            4'd9:    lit = 8'h67;
            default: lit = 8'h00;
        endcase
        return ~lit;
    endfunction

endpackage

// ===== sv/mss_if.sv =====
// valid/ready channel interfaces for scanner input and output
interface mss_in_if;
    import mss_pkg::*;
    logic             valid;
    logic             ready;
    logic [NUM_W-1:0] number;
    modport source(output valid, output number, input ready);
    modport sink(input valid, input number, output ready);
endinterface

interface mss_out_if;
    import mss_pkg::*;
    logic             valid;
    logic             ready;
    logic [SEG_W-1:0] segments;
    logic [POS_W-1:0] position;
    modport source(output valid, output segments, output position, input ready);
    modport sink(input valid, input segments, input position, output ready);
endinterface

// ===== sv/mss_front.sv =====
// front end: accepts numbers, tracks the scan slot, extracts the slot's quotient
module mss_front (
    input  logic               clk,
    input  logic               rst_n,
    mss_in_if.sink             in_chan,
    input  mss_pkg::cfg_t      cfg,
    input  logic               queue_full,
    output logic               push,
    output mss_pkg::slot_item_t push_item
);
    import mss_pkg::*;

    pos_t               slot_reg;
    pos_t               slot_next;
    logic [QUOT_W-1:0]  n_sat;
    logic [15:0]        recip;
    logic [SHIFT_W-1:0] shift;
    logic [MULT_W-1:0]  prod;
    logic               blank;

    assign in_chan.ready = !queue_full;
    assign push          = in_chan.valid && !queue_full;

    assign n_sat = (in_chan.number > NUM_MAX) ? QUOT_W'(NUM_MAX) : in_chan.number[QUOT_W-1:0];

    always_comb
    begin
        recip = 16'd1;
        shift = '0;
        blank = 1'b0;
        case (slot_reg)
            POS_TENS:
            begin
                recip = RECIP_10;
                shift = SHIFT_10;
                blank = (n_sat < 14'd10);
            end
            POS_HUNDREDS:
            begin
                recip = RECIP_100;
                shift = SHIFT_100;
                blank = (n_sat < 14'd100);
            end
            POS_THOUSANDS:
            begin
                recip = RECIP_1000;
                shift = SHIFT_1000;
                blank = (n_sat < 14'd1000);
            end
            default:
            begin
                recip = 16'd1;
                shift = '0;
                blank = 1'b0;
            end
        endcase
    end

    assign prod = MULT_W'(n_sat) * MULT_W'(recip);

    assign push_item.position = slot_reg;
    assign push_item.quot     = QUOT_W'(prod >> shift);
    assign push_item.blank    = blank && !cfg.zero_fill;

    always_comb
    begin
        case (slot_reg)
            POS_ONES:     slot_next = POS_TENS;
            POS_TENS:     slot_next = POS_COLON;
            POS_COLON:    slot_next = POS_HUNDREDS;
            POS_HUNDREDS: slot_next = POS_THOUSANDS;
            default:      slot_next = POS_ONES;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= POS_ONES;
        end
        else if (push)
        begin
            slot_reg <= slot_next;
        end
    end

endmodule

// ===== sv/mss_queue.sv =====
// two-entry queue between front and back ends
module mss_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  mss_pkg::slot_item_t push_item,
    output logic                full,
    input  logic                pop,
    output logic                head_valid,
    output mss_pkg::slot_item_t head_item
);
    import mss_pkg::*;

    slot_item_t mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_item  = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

endmodule

// ===== sv/mss_back.sv =====
// back end: digit from quotient, segment lookup and output register
module mss_back (
    input  logic                clk,
    input  logic                rst_n,
    input  mss_pkg::cfg_t       cfg,
    input  logic                head_valid,
    input  mss_pkg::slot_item_t head_item,
    output logic                pop,
    mss_out_if.source           out_chan
);
    import mss_pkg::*;

    logic [MULT_W-1:0]  prod;
    logic [QUOT_W-1:0]  quot10;
    logic [QUOT_W-1:0]  rem;
    logic [SEG_W-1:0]   seg;
    logic               valid_reg;
    logic [SEG_W-1:0]   seg_reg;
    logic [POS_W-1:0]   pos_reg;

    // remainder by ten through the reciprocal
    assign prod   = MULT_W'(head_item.quot) * MULT_W'(RECIP_10);
    assign quot10 = QUOT_W'(prod >> SHIFT_10);
    assign rem    = head_item.quot - ((quot10 << 3) + (quot10 << 1));

    always_comb
    begin
        if (head_item.position == POS_COLON)
        begin
            if (cfg.colon_mode[COLON_DOT_BIT])
            begin
                seg = ~COLON_DOT_LIT;
            end
            else if (cfg.colon_mode[COLON_ON_BIT])
            begin
                seg = ~COLON_LIT;
            end
            else
            begin
                seg = SEG_DARK;
            end
        end
        else if (head_item.blank)
        begin
            seg = SEG_DARK;
        end
        else
        begin
            seg = digit_pattern(rem[DIGIT_W-1:0]);
        end
    end

    assign pop = head_valid && (!valid_reg || out_chan.ready);

    assign out_chan.valid    = valid_reg;
    assign out_chan.segments = seg_reg;
    assign out_chan.position = pos_reg;

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            seg_reg <= seg;
            pos_reg <= head_item.position;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_chan.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

endmodule

// ===== sv/mux_seven_segment_scanner.sv =====
// top level of the multiplexed seven-segment scanner
// each transfer on in_chan is one scan tick carrying a 16-bit number; values
// above 9999 show as 9999. every tick gives exactly one transfer on out_chan:
// the active-low segment pattern and the position of the current slot, which
// steps ones, tens, colon, hundreds, thousands and wraps back to ones.
// the front end saturates the number and pulls out the slot's quotient with a
// reciprocal multiply, a two-entry queue decouples it from the back end, which
// takes the remainder by ten, looks up the pattern and registers the result.
// the result is registered first in a queue entry and then in the output
// register before its out_chan transfer; one tick is taken every
// cycle while the output is drained.
// when the receiver stalls, the result register holds and the queue fills;
// in_chan.ready drops once both queue entries are occupied.
// configuration: cfg_we with cfg_index 0 writes zero_fill, index 1 colon_mode;
// write only while no ticks are in flight.
// reset returns the slot to ones, empties the queue and output, and sets
// zero_fill to 0 and colon_mode to 1.
module mux_seven_segment_scanner (
    input  logic                              clk,
    input  logic                              rst_n,
    mss_in_if.sink                            in_chan,
    mss_out_if.source                         out_chan,
    input  logic                              cfg_we,
    input  logic [mss_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mss_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import mss_pkg::*;

    cfg_t       cfg_reg;
    logic       push;
    slot_item_t push_item;
    logic       queue_full;
    logic       pop;
    logic       head_valid;
    slot_item_t head_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.zero_fill  <= 1'b0;
            cfg_reg.colon_mode <= 2'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_ZERO_FILL:  cfg_reg.zero_fill  <= cfg_data[0];
                CFG_COLON_MODE: cfg_reg.colon_mode <= cfg_data[1:0];
                default:        cfg_reg            <= cfg_reg;
            endcase
        end
    end

    mss_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_chan    (in_chan),
        .cfg        (cfg_reg),
        .queue_full (queue_full),
        .push       (push),
        .push_item  (push_item)
    );

    mss_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    mss_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .out_chan   (out_chan)
    );

endmodule

// ===== test/tb_top.sv =====
// self-checking testbench for the multiplexed seven-segment scanner
module tb_top;
    import mss_pkg::*;

    localparam int TICKS_PER_SETTING = 225;
    localparam int NUM_SETTINGS      = 6;
    localparam int NUM_DIRECTED      = 25;
    localparam int CYCLE_LIMIT       = 200000;
    localparam int SETTLE_CYCLES     = 8;

    // lit segments for 0..9, active high
    localparam logic [SEG_W-1:0] DIGIT_LIT [10] = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7C, 8'h07, 8'h7F, 8'h67
    };

    typedef struct packed {
        logic [SEG_W-1:0] segments;
        pos_t             position;
    } glyph_t;

    typedef struct packed {
        logic             zero_fill;
        logic [1:0]       colon_mode;
        logic [NUM_W-1:0] number;
        logic             known;
        logic [SEG_W-1:0] segments;
        pos_t             position;
    } directed_row_t;

    // zero fill, colon mode, number, whether the result is typed in, segments, slot
    localparam directed_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
        '{1'b0, 2'd1, 16'd0,     1'b1, 8'hC0, POS_ONES},
        '{1'b0, 2'd1, 16'd0,     1'b1, 8'hFF, POS_TENS},
        '{1'b0, 2'd1, 16'd0,     1'b1, 8'hFC, POS_COLON},
        '{1'b0, 2'd1, 16'd0,     1'b1, 8'hFF, POS_HUNDREDS},
        '{1'b0, 2'd1, 16'd0,     1'b1, 8'hFF, POS_THOUSANDS},
        '{1'b0, 2'd1, 16'd65535, 1'b1, 8'h98, POS_ONES},
        '{1'b0, 2'd1, 16'd10000, 1'b1, 8'h98, POS_TENS},
        '{1'b0, 2'd1, 16'd9999,  1'b1, 8'hFC, POS_COLON},
        '{1'b0, 2'd1, 16'd9999,  1'b1, 8'h98, POS_HUNDREDS},
        '{1'b0, 2'd1, 16'd9999,  1'b1, 8'h98, POS_THOUSANDS},
        '{1'b1, 2'd0, 16'd1234,  1'b1, 8'h99, POS_ONES},
        '{1'b1, 2'd0, 16'd1234,  1'b0, 8'h00, POS_TENS},
        '{1'b1, 2'd0, 16'd7,     1'b1, 8'hFF, POS_COLON},
        '{1'b1, 2'd0, 16'd7,     1'b1, 8'hC0, POS_HUNDREDS},
        '{1'b1, 2'd0, 16'd0,     1'b1, 8'hC0, POS_THOUSANDS},
        '{1'b0, 2'd2, 16'd5,     1'b0, 8'h00, POS_ONES},
        '{1'b0, 2'd2, 16'd100,   1'b0, 8'h00, POS_TENS},
        '{1'b0, 2'd2, 16'd0,     1'b1, 8'hF8, POS_COLON},
        '{1'b0, 2'd2, 16'd56,    1'b1, 8'hFF, POS_HUNDREDS},
        '{1'b0, 2'd2, 16'd8000,  1'b0, 8'h00, POS_THOUSANDS},
        '{1'b0, 2'd3, 16'd1000,  1'b0, 8'h00, POS_ONES},
        '{1'b0, 2'd3, 16'd1005,  1'b0, 8'h00, POS_TENS},
        '{1'b0, 2'd3, 16'd1,     1'b1, 8'hF8, POS_COLON},
        '{1'b0, 2'd3, 16'd32768, 1'b0, 8'h00, POS_HUNDREDS},
        '{1'b0, 2'd3, 16'd1,     1'b1, 8'hFF, POS_THOUSANDS}
    };

    // register settings for the random phases, extremes included
    localparam logic       PHASE_ZERO_FILL  [NUM_SETTINGS] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
    localparam logic [1:0] PHASE_COLON_MODE [NUM_SETTINGS] = '{2'd0, 2'd2, 2'd3, 2'd1, 2'd1, 2'd2};

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    mss_in_if  in_bus ();
    mss_out_if out_bus ();

    mux_seven_segment_scanner u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_chan   (in_bus),
        .out_chan  (out_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // scanner state as predicted
    logic       shadow_zero_fill;
    logic [1:0] shadow_colon_mode;
    pos_t       shadow_slot;

    glyph_t awaited_glyphs [$];
    int     mismatch_count;
    int     glyphs_checked;
    int     ticks_sent;
    int     saturated_ticks;
    int     settings_written;
    int     cycle_count;
    logic   sender_calm;

    function automatic glyph_t predict_glyph(input logic [NUM_W-1:0] number);
        int     n;
        int     ones;
        int     tens;
        int     hundreds;
        int     thousands;
        logic   dark_thousands;
        logic   dark_hundreds;
        logic   dark_tens;
        glyph_t g;
        n = (number > NUM_MAX) ? int'(NUM_MAX) : int'(number);
        ones      = n % 10;
        tens      = (n / 10) % 10;
        hundreds  = (n / 100) % 10;
        thousands = n / 1000;
        // leading zeros go dark only as a run from the thousands down
        dark_thousands = !shadow_zero_fill && thousands == 0;
        dark_hundreds  = dark_thousands && hundreds == 0;
        dark_tens      = dark_hundreds && tens == 0;
        g.position = shadow_slot;
        case (shadow_slot)
            POS_TENS:      g.segments = dark_tens ? SEG_DARK : ~DIGIT_LIT[tens];
            POS_HUNDREDS:  g.segments = dark_hundreds ? SEG_DARK : ~DIGIT_LIT[hundreds];
            POS_THOUSANDS: g.segments = dark_thousands ? SEG_DARK : ~DIGIT_LIT[thousands];
            POS_COLON:
            begin
                if (shadow_colon_mode[COLON_DOT_BIT])
                    g.segments = ~COLON_DOT_LIT;
                else if (shadow_colon_mode[COLON_ON_BIT])
                    g.segments = ~COLON_LIT;
                else
                    g.segments = SEG_DARK;
            end
            default:       g.segments = ~DIGIT_LIT[ones];
        endcase
        shadow_slot = (shadow_slot == POS_THOUSANDS) ? POS_ONES : pos_t'(shadow_slot + 1);
        return g;
    endfunction

    // offer one tick and wait for its transfer; a known glyph overrides the prediction
    task automatic send_tick(input logic [NUM_W-1:0] number, input logic known,
                             input glyph_t known_glyph);
        int     gap;
        glyph_t g;
        gap = sender_calm ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_bus.valid  <= 1'b1;
        in_bus.number <= number;
        do
            @(posedge clk);
        while (!in_bus.ready);
        g = predict_glyph(number);
        awaited_glyphs.push_back(known ? known_glyph : g);
        ticks_sent++;
        if (number > NUM_MAX)
            saturated_ticks++;
    endtask

    // stop offering ticks until every outstanding glyph has been drained
    task automatic hold_until_drained();
        in_bus.valid <= 1'b0;
        @(posedge clk);
        while (awaited_glyphs.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_settings(input logic zero_fill, input logic [1:0] colon_mode);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_ZERO_FILL;
        cfg_data  <= CFG_DATA_W'(zero_fill);
        @(posedge clk);
        cfg_index <= CFG_COLON_MODE;
        cfg_data  <= colon_mode;
        @(posedge clk);
        cfg_we <= 1'b0;
        shadow_zero_fill  = zero_fill;
        shadow_colon_mode = colon_mode;
        settings_written++;
    endtask

    // receiving side: random stalls, compare each transfer with the oldest prediction
    initial
    begin
        int     gap;
        int     since_redraw;
        logic   calm;
        glyph_t want;
        calm = 1'b0;
        since_redraw = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (since_redraw == 40)
            begin
                calm = ($urandom_range(0, 2) == 0);
                since_redraw = 0;
            end
            gap = calm ? 0 : $urandom_range(0, 8);
            if (gap > 0)
            begin
                out_bus.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_bus.ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_bus.valid);
            since_redraw++;
            glyphs_checked++;
            if (awaited_glyphs.size() == 0)
            begin
                $display("%0t: unexpected transfer, segments %h position %0d", $time,
                         out_bus.segments, out_bus.position);
                mismatch_count++;
            end
            else
            begin
                want = awaited_glyphs.pop_front();
                if (out_bus.segments !== want.segments)
                begin
                    $display("%0t: segments expected %h actual %h (slot %0d)", $time,
                             want.segments, out_bus.segments, want.position);
                    mismatch_count++;
                end
                if (out_bus.position !== want.position)
                begin
                    $display("%0t: position expected %0d actual %0d", $time,
                             want.position, out_bus.position);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("mux_seven_segment_scanner: mismatch");
            $finish;
        end
    end

    initial
    begin
        directed_row_t row;
        glyph_t        typed_glyph;
        logic [NUM_W-1:0] number;
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = CFG_ZERO_FILL;
        cfg_data          = '0;
        in_bus.valid      = 1'b0;
        in_bus.number     = '0;
        out_bus.ready     = 1'b0;
        cycle_count       = 0;
        mismatch_count    = 0;
        glyphs_checked    = 0;
        ticks_sent        = 0;
        saturated_ticks   = 0;
        settings_written  = 0;
        sender_calm       = 1'b0;
        shadow_zero_fill  = 1'b0;
        shadow_colon_mode = 2'd1;
        shadow_slot       = POS_ONES;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < NUM_DIRECTED; i++)
        begin
            row = DIRECTED_ROWS[i];
            if (row.zero_fill != shadow_zero_fill || row.colon_mode != shadow_colon_mode)
            begin
                hold_until_drained();
                write_settings(row.zero_fill, row.colon_mode);
            end
            typed_glyph.segments = row.segments;
            typed_glyph.position = row.position;
            send_tick(row.number, row.known, typed_glyph);
        end

        for (int p = 0; p < NUM_SETTINGS; p++)
        begin
            hold_until_drained();
            write_settings(PHASE_ZERO_FILL[p], PHASE_COLON_MODE[p]);
            for (int i = 0; i < TICKS_PER_SETTING; i++)
            begin
                if (i % 50 == 0)
                    sender_calm = ($urandom_range(0, 2) == 0);
                // mostly short numbers so the blanking runs get exercised
                case ($urandom_range(0, 9))
                    0, 1:    number = NUM_W'($urandom_range(0, 9));
                    2, 3:    number = NUM_W'($urandom_range(10, 99));
                    4:       number = NUM_W'($urandom_range(100, 999));
                    5, 6:    number = NUM_W'($urandom_range(1000, 9999));
                    7:       number = NUM_W'($urandom_range(9990, 10010));
                    default: number = NUM_W'($urandom_range(0, 65535));
                endcase
                send_tick(number, 1'b0, '0);
                if (i == TICKS_PER_SETTING / 2 && p == 2)
                    hold_until_drained();
            end
        end

        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (awaited_glyphs.size() != 0)
        begin
            $display("%0t: %0d glyphs never arrived", $time, awaited_glyphs.size());
            mismatch_count++;
        end
        $display("sent %0d scan ticks (%0d above the display range), checked %0d glyphs",
                 ticks_sent, saturated_ticks, glyphs_checked);
        $display("went through %0d register settings, all colon modes and both fill modes",
                 settings_written);
        if (mismatch_count == 0)
            $display("mux_seven_segment_scanner: match");
        else
            $display("mux_seven_segment_scanner: mismatch");
        $finish;
    end

endmodule
